// ===== rtl/rpzp_pkg.sv =====
// shared types, constants and trig table for the point plotter
package rpzp_pkg;

    localparam int MAX_CELLS   = 16384;
    localparam int FOCAL_SCALE = 40;
    localparam int AW          = $clog2(MAX_CELLS);

    localparam logic [7:0] CHAR_SPACE = 8'd32;

    typedef enum logic [2:0] {
        REG_ANGLE_A       = 3'd0,
        REG_ANGLE_B       = 3'd1,
        REG_ANGLE_C       = 3'd2,
        REG_VIEW_DISTANCE = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_LIGHT_ENABLE  = 3'd6,
        REG_DARK_INVERT   = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        OP_PLOT = 1'b0,
        OP_READ = 1'b1
    } opcode_t;

    typedef logic [14:0] sin_tab_t [0:256];

    // quarter-wave sine in q14, polynomial evaluated in q16
    // divides by 42, 20 and 6 are exact reciprocal multiplies for operands below 2^18
    function automatic sin_tab_t gen_sin_tab();
        sin_tab_t   tab;
        logic [63:0] x, x2, u, v, w, s, q;
        for (int t = 0; t <= 256; t++)
        begin
            x  = (64'(t) * 64'd102944 + 64'd128) >> 8;
            x2 = (x * x) >> 16;
            u  = 64'd65536 - ((x2 * 64'd399458) >> 24);
            v  = 64'd65536 - ((((x2 * u) >> 16) * 64'd419431) >> 23);
            w  = 64'd65536 - ((((x2 * v) >> 16) * 64'd349526) >> 21);
            s  = (x * w) >> 16;
            q  = (s + 64'd2) >> 2;
            if (q > 64'd16384)
            begin
                q = 64'd16384;
            end
            tab[t] = q[14:0];
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = gen_sin_tab();

    function automatic logic signed [15:0] sin_q14(input logic [9:0] a);
        logic [8:0]  t;
        logic [15:0] s;
        t = a[8] ? (9'd256 - {1'b0, a[7:0]}) : {1'b0, a[7:0]};
        s = {1'b0, SIN_TAB[t]};
        return a[9] ? -signed'(s) : signed'(s);
    endfunction

    function automatic logic signed [15:0] cos_q14(input logic [9:0] a);
        return sin_q14(a + 10'd256);
    endfunction

endpackage

// ===== rtl/rotate_project_zbuffer_plot.sv =====
// z-buffered perspective point plotter for a character frame
//
// start is taken when busy is low; each item gives one result, shown for one
// cycle with done high, and the receiver cannot stall it. After reset the
// block sweeps its cell memory clear, one cell a cycle, and busy stays high
// until the sweep is through. A read item passes S_RDWAIT and S_RDOUT.
// A plot rotates the point, then runs the 26-step radix-2 divider that
// forms depth, column and row in three parallel lanes, ahead of one
// read-modify-write of the cell memory; a point behind the viewer ends before
// the divider, and one outside the frame ends before the write.
module rotate_project_zbuffer_plot (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  logic                 opcode,
    input  logic signed [7:0]    point_x,
    input  logic signed [7:0]    point_y,
    input  logic signed [7:0]    point_z,
    input  logic [7:0]           face_char,
    input  logic signed [10:0]   light_level,
    input  logic [13:0]          cell_index,
    input  logic                 cfg_write,
    input  rpzp_pkg::cfg_reg_t   cfg_index,
    input  logic [9:0]           cfg_data,
    output logic                 drawn,
    output logic [13:0]          target_index,
    output logic [7:0]           cell_char
);
    import rpzp_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_TRIG, S_ROT1, S_ROT2, S_ROT3, S_NUM, S_MAG,
        S_DIV, S_SAT, S_IDX, S_LOOK, S_TEST, S_RDWAIT, S_RDOUT
    } state_t;

    localparam logic signed [9:0] FOC_X = 10'(2 * FOCAL_SCALE);
    localparam logic signed [9:0] FOC_Y = 10'(FOCAL_SCALE);
    localparam logic [25:0]       PROJ_LIMIT = 26'd1 << 24;

    state_t state_reg;

    logic [9:0] angle_a_reg, angle_b_reg, angle_c_reg, view_distance_reg;
    logic [7:0] screen_width_reg, screen_height_reg;
    logic       light_enable_reg, dark_invert_reg;

    logic             done_reg, drawn_reg;
    logic [13:0]      target_reg;
    logic [7:0]       char_out_reg;
    logic [AW-1:0]    clr_reg;

    // latched item
    logic                op_reg;
    logic signed [7:0]   px_reg, py_reg, pz_reg;
    logic [7:0]          face_reg;
    logic signed [10:0]  light_reg;
    logic [13:0]         ci_reg;

    // datapath
    logic signed [15:0]  sa_reg, ca_reg, sb_reg, cb_reg, sc_reg, cc_reg;
    logic signed [23:0]  p_reg, q_reg;
    logic signed [39:0]  r_reg, t_reg;
    logic signed [53:0]  x_reg, y_reg, z_reg;
    logic signed [63:0]  n1_reg, n2_reg;
    logic [63:0]         mag_reg [3];
    logic [2:0]          neg_reg, ovf_reg;
    logic [25:0]         quo_reg [3];
    logic [79:0]         dsr_reg;
    logic [4:0]          bit_reg;
    logic signed [25:0]  col_reg, row_reg;
    logic [15:0]         depth_reg;
    logic signed [35:0]  idx_reg;

    // cell memory: {depth, char}
    logic [23:0]   mem [MAX_CELLS];
    logic [23:0]   rd_data_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [23:0]   wr_data;
    logic          wr_en;

    logic [2:0]          ge;
    logic [15:0]         wh;
    logic                in_frame, ci_ok, depth_win;
    logic [7:0]          plot_char;
    logic signed [11:0]  lvl;

    function automatic logic [7:0] shade(input logic signed [11:0] l);
        priority if (l < -12'sd409) return 8'h40;
        else if (l < -12'sd256)     return 8'h23;
        else if (l < -12'sd128)     return 8'h24;
        else if (l < 12'sd0)        return 8'h2b;
        else if (l < 12'sd128)      return 8'h21;
        else if (l < 12'sd256)      return 8'h3b;
        else if (l < 12'sd410)      return 8'h7e;
        else                        return 8'h2e;
    endfunction

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign drawn        = drawn_reg;
    assign target_index = target_reg;
    assign cell_char    = char_out_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            ge[l] = ({16'd0, mag_reg[l]} >= dsr_reg);
        end
        wh        = 16'(screen_width_reg) * 16'(screen_height_reg);
        in_frame  = (idx_reg >= 36'sd0) && (idx_reg < signed'(36'(wh)))
                    && (idx_reg < signed'(36'(MAX_CELLS)));
        ci_ok     = ({3'd0, ci_reg} < 17'(MAX_CELLS));
        depth_win = (depth_reg > rd_data_reg[23:8]);
        lvl       = dark_invert_reg ? -12'(light_reg) : 12'(light_reg);
        plot_char = light_enable_reg ? shade(lvl) : face_reg;
        rd_addr   = (op_reg == OP_READ) ? AW'(ci_reg) : AW'(idx_reg);
        wr_en     = 1'b0;
        wr_addr   = rd_addr;
        wr_data   = {16'd0, CHAR_SPACE};
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
            end
            S_TEST:
            begin
                wr_en   = depth_win;
                wr_data = {depth_reg, plot_char};
            end
            S_RDOUT:
            begin
                wr_en = ci_ok;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // control, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_reg           <= '0;
            angle_a_reg       <= 10'd0;
            angle_b_reg       <= 10'd0;
            angle_c_reg       <= 10'd0;
            view_distance_reg <= 10'd120;
            screen_width_reg  <= 8'd80;
            screen_height_reg <= 8'd24;
            light_enable_reg  <= 1'b0;
            dark_invert_reg   <= 1'b0;
            done_reg          <= 1'b0;
            drawn_reg         <= 1'b0;
            target_reg        <= 14'd0;
            char_out_reg      <= 8'd0;
            bit_reg           <= 5'd0;
        end
        else
        begin
            done_reg  <= (state_reg == S_TEST) || (state_reg == S_RDOUT)
                         || ((state_reg == S_NUM) && (z_reg <= 54'sd0))
                         || ((state_reg == S_LOOK) && !in_frame);
            drawn_reg <= (state_reg == S_TEST) && depth_win;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_ANGLE_A:       angle_a_reg       <= cfg_data;
                    REG_ANGLE_B:       angle_b_reg       <= cfg_data;
                    REG_ANGLE_C:       angle_c_reg       <= cfg_data;
                    REG_VIEW_DISTANCE: view_distance_reg <= cfg_data;
                    REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[7:0];
                    REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[7:0];
                    REG_LIGHT_ENABLE:  light_enable_reg  <= cfg_data[0];
                    REG_DARK_INVERT:   dark_invert_reg   <= cfg_data[0];
                endcase
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(MAX_CELLS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= (opcode == OP_READ) ? S_RDWAIT : S_TRIG;
                    end
                end
                S_TRIG: state_reg <= S_ROT1;
                S_ROT1: state_reg <= S_ROT2;
                S_ROT2: state_reg <= S_ROT3;
                S_ROT3: state_reg <= S_NUM;
                S_NUM:
                begin
                    // point at or behind the eye never draws
                    if (z_reg <= 54'sd0)
                    begin
                        state_reg    <= S_IDLE;
                        target_reg   <= 14'd0;
                        char_out_reg <= 8'd0;
                    end
                    else
                    begin
                        state_reg <= S_MAG;
                    end
                end
                S_MAG:
                begin
                    bit_reg   <= 5'd25;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == 5'd0)
                    begin
                        state_reg <= S_SAT;
                    end
                end
                S_SAT: state_reg <= S_IDX;
                S_IDX: state_reg <= S_LOOK;
                S_LOOK:
                begin
                    if (in_frame)
                    begin
                        state_reg <= S_TEST;
                    end
                    else
                    begin
                        state_reg    <= S_IDLE;
                        target_reg   <= 14'd0;
                        char_out_reg <= 8'd0;
                    end
                end
                S_TEST:
                begin
                    state_reg    <= S_IDLE;
                    target_reg   <= depth_win ? 14'(idx_reg) : 14'd0;
                    char_out_reg <= depth_win ? plot_char : 8'd0;
                end
                S_RDWAIT: state_reg <= S_RDOUT;
                S_RDOUT:
                begin
                    state_reg    <= S_IDLE;
                    target_reg   <= ci_reg;
                    char_out_reg <= ci_ok ? rd_data_reg[7:0] : CHAR_SPACE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg    <= opcode;
                px_reg    <= point_x;
                py_reg    <= point_y;
                pz_reg    <= point_z;
                face_reg  <= face_char;
                light_reg <= light_level;
                ci_reg    <= cell_index;
            end
            S_TRIG:
            begin
                sa_reg <= sin_q14(angle_a_reg);
                ca_reg <= cos_q14(angle_a_reg);
                sb_reg <= sin_q14(angle_b_reg);
                cb_reg <= cos_q14(angle_b_reg);
                sc_reg <= sin_q14(angle_c_reg);
                cc_reg <= cos_q14(angle_c_reg);
            end
            S_ROT1:
            begin
                p_reg <= py_reg * sa_reg - pz_reg * ca_reg;
                q_reg <= py_reg * ca_reg + pz_reg * sa_reg;
            end
            S_ROT2:
            begin
                r_reg <= sb_reg * p_reg + ((px_reg * cb_reg) <<< 14);
                t_reg <= ((px_reg * sb_reg) <<< 14) - cb_reg * p_reg;
            end
            S_ROT3:
            begin
                x_reg <= cc_reg * r_reg + ((sc_reg * q_reg) <<< 14);
                y_reg <= ((cc_reg * q_reg) <<< 14) - sc_reg * r_reg;
                z_reg <= (t_reg <<< 14) + (signed'({1'b0, view_distance_reg}) <<< 42);
            end
            S_NUM:
            begin
                n1_reg <= signed'({1'b0, screen_width_reg[7:1]}) * z_reg + FOC_X * x_reg;
                n2_reg <= signed'({1'b0, screen_height_reg[7:1]}) * z_reg + FOC_Y * y_reg;
            end
            S_MAG:
            begin
                mag_reg[0] <= 64'd1 << 58;
                mag_reg[1] <= n1_reg[63] ? 64'(-n1_reg) : 64'(n1_reg);
                mag_reg[2] <= n2_reg[63] ? 64'(-n2_reg) : 64'(n2_reg);
                neg_reg    <= {n2_reg[63], n1_reg[63], 1'b0};
                ovf_reg    <= 3'b000;
                for (int l = 0; l < 3; l++)
                begin
                    quo_reg[l] <= 26'd0;
                end
                dsr_reg <= 80'(z_reg[52:0]) << 25;
            end
            S_DIV:
            begin
                // one quotient bit per lane; a hit on the top bit means saturation
                for (int l = 0; l < 3; l++)
                begin
                    if (ge[l])
                    begin
                        mag_reg[l] <= mag_reg[l] - 64'(dsr_reg);
                    end
                    quo_reg[l] <= {quo_reg[l][24:0], ge[l]};
                    if (ge[l] && (bit_reg == 5'd25))
                    begin
                        ovf_reg[l] <= 1'b1;
                    end
                end
                dsr_reg <= dsr_reg >> 1;
            end
            S_SAT:
            begin
                depth_reg <= (ovf_reg[0] || (quo_reg[0] > 26'd65535))
                             ? 16'hffff : quo_reg[0][15:0];
                col_reg <= (ovf_reg[1] || (quo_reg[1] > PROJ_LIMIT))
                           ? (neg_reg[1] ? -signed'(PROJ_LIMIT) : signed'(PROJ_LIMIT))
                           : (neg_reg[1] ? -signed'(quo_reg[1]) : signed'(quo_reg[1]));
                row_reg <= (ovf_reg[2] || (quo_reg[2] > PROJ_LIMIT))
                           ? (neg_reg[2] ? -signed'(PROJ_LIMIT) : signed'(PROJ_LIMIT))
                           : (neg_reg[2] ? -signed'(quo_reg[2]) : signed'(quo_reg[2]));
            end
            S_IDX:
            begin
                idx_reg <= col_reg + row_reg * signed'({1'b0, screen_width_reg});
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

endmodule

// ===== rtl/rpzp_checker.sv =====
// port-level checks for the point plotter, bound to the top level
module rpzp_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic drawn
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while block busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_drawn_done: assert property (@(posedge clk) disable iff (!rst_n)
        drawn |-> done)
        else $error("drawn without a result strobe");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without an item in flight");

endmodule

bind rotate_project_zbuffer_plot rpzp_checker u_rpzp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .drawn (drawn)
);

// ===== bench/tb_top.sv =====
// self-checking bench for the z-buffered perspective point plotter
`timescale 1ns / 1ps

module tb_top;
    import rpzp_pkg::*;

    typedef struct packed {
        logic        drawn;
        logic [13:0] index;
        logic [7:0]  ch;
    } cell_result_t;

    typedef struct {
        opcode_t            op;
        logic signed [7:0]  x;
        logic signed [7:0]  y;
        logic signed [7:0]  z;
        logic [7:0]         fc;
        logic signed [10:0] ll;
        logic [13:0]        ci;
        bit                 typed;
        cell_result_t       res;
    } stim_row_t;

    typedef struct {
        int a, b, c, vd, w, h, le, di;
    } view_setup_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                done;
    opcode_t             opcode;
    logic signed [7:0]   point_x;
    logic signed [7:0]   point_y;
    logic signed [7:0]   point_z;
    logic [7:0]          face_char;
    logic signed [10:0]  light_level;
    logic [13:0]         cell_index;
    logic                cfg_write;
    cfg_reg_t            cfg_index;
    logic [9:0]          cfg_data;
    logic                drawn;
    logic [13:0]         target_index;
    logic [7:0]          cell_char;

    rotate_project_zbuffer_plot u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .opcode(opcode), .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .face_char(face_char), .light_level(light_level), .cell_index(cell_index),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .drawn(drawn), .target_index(target_index), .cell_char(cell_char)
    );

    // model copy of the frame and the view
    logic [15:0]  depth_mem [0:MAX_CELLS-1];
    logic [7:0]   char_mem  [0:MAX_CELLS-1];
    logic [9:0]   m_angle_a, m_angle_b, m_angle_c, m_view_dist;
    logic [7:0]   m_width, m_height;
    logic         m_light, m_dark;

    cell_result_t expected_cells [$];
    int           painted_cells [$];
    int           err_count;
    int           items_sent;
    int           draws_seen;
    int           phases_run;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #1_000_000;
        $display("timeout waiting for results");
        $display("TB_ERROR");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        err_count++;
    endtask

    // quarter-wave polynomial sine, q14
    function automatic longint sine14(input logic [9:0] a);
        longint unsigned t, x, x2, u, v, w, s, q;
        t  = a[8] ? (256 - a[7:0]) : a[7:0];
        x  = (t * 102944 + 128) >> 8;
        x2 = (x * x) >> 16;
        u  = 65536 - x2 / 42;
        v  = 65536 - (x2 * u) / (20 * 65536);
        w  = 65536 - (x2 * v) / (6 * 65536);
        s  = (x * w) >> 16;
        q  = (s + 2) >> 2;
        if (q > 16384)
        begin
            q = 16384;
        end
        return a[9] ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint cosine14(input logic [9:0] a);
        logic [9:0] b;
        b = a + 10'd256;
        return sine14(b);
    endfunction

    function automatic longint div_sat(input longint n, input longint d);
        longint q;
        q = n / d;
        if (q > (64'sd1 <<< 24))
        begin
            q = 64'sd1 <<< 24;
        end
        if (q < -(64'sd1 <<< 24))
        begin
            q = -(64'sd1 <<< 24);
        end
        return q;
    endfunction

    function automatic logic [7:0] shade_char(input longint l);
        if (l < -409) return "@";
        if (l < -256) return "#";
        if (l < -128) return "$";
        if (l < 0)    return "+";
        if (l < 128)  return "!";
        if (l < 256)  return ";";
        if (l < 410)  return "~";
        return ".";
    endfunction

    // work out one item's result and update the model frame
    function automatic cell_result_t plot_or_read(input opcode_t op,
            input logic signed [7:0] px, input logic signed [7:0] py,
            input logic signed [7:0] pz, input logic [7:0] fc,
            input logic signed [10:0] ll, input logic [13:0] ci);
        cell_result_t   r;
        longint         i, j, k, sa, ca, sb, cb, sc, cc, bx, by, bz;
        longint         wd, ht, col, row, idx, l;
        longint         sq;
        longint unsigned dq;
        logic [15:0]    dep;
        r  = '0;
        sq = 16384;
        if (op == OP_READ)
        begin
            r.index = ci;
            r.ch = char_mem[ci];
            char_mem[ci] = CHAR_SPACE;
            depth_mem[ci] = 16'd0;
            return r;
        end
        i  = px;
        j  = py;
        k  = pz;
        sa = sine14(m_angle_a);
        ca = cosine14(m_angle_a);
        sb = sine14(m_angle_b);
        cb = cosine14(m_angle_b);
        sc = sine14(m_angle_c);
        cc = cosine14(m_angle_c);
        bx = j * sa * sb * cc - k * ca * sb * cc + j * ca * sc * sq
           + k * sa * sc * sq + i * cb * cc * sq;
        by = j * ca * cc * sq + k * sa * cc * sq - j * sa * sb * sc
           + k * ca * sb * sc - i * cb * sc * sq;
        bz = (k * ca * cb - j * sa * cb) * sq + i * sb * sq * sq
           + longint'(m_view_dist) * (64'sd1 <<< 42);
        if (bz <= 0)
        begin
            return r;
        end
        dq  = (64'd1 << 58) / longint'(bz);
        dep = (dq > 65535) ? 16'hffff : dq[15:0];
        wd  = m_width;
        ht  = m_height;
        col = div_sat((wd / 2) * bz + 2 * FOCAL_SCALE * bx, bz);
        row = div_sat((ht / 2) * bz + FOCAL_SCALE * by, bz);
        idx = col + row * wd;
        if (idx < 0 || idx >= wd * ht || idx >= MAX_CELLS)
        begin
            return r;
        end
        if (dep <= depth_mem[idx])
        begin
            return r;
        end
        if (m_light)
        begin
            l = ll;
            if (m_dark)
            begin
                l = -l;
            end
            r.ch = shade_char(l);
        end
        else
        begin
            r.ch = fc;
        end
        depth_mem[idx] = dep;
        char_mem[idx]  = r.ch;
        r.drawn = 1'b1;
        r.index = idx[13:0];
        return r;
    endfunction

    // accept items and check results at the rising edge
    stim_row_t cur_row;
    always @(posedge clk)
    begin
        cell_result_t want;
        if (done)
        begin
            if (expected_cells.size() == 0)
            begin
                report("result with nothing pending, index", target_index, -1);
            end
            else
            begin
                want = expected_cells.pop_front();
                if (drawn !== want.drawn) report("drawn", drawn, want.drawn);
                if (target_index !== want.index) report("target_index", target_index, want.index);
                if (cell_char !== want.ch) report("cell_char", cell_char, want.ch);
                if (drawn === 1'b1) draws_seen++;
            end
        end
        if (start && !busy)
        begin
            want = plot_or_read(opcode, point_x, point_y, point_z, face_char,
                                light_level, cell_index);
            if (cur_row.typed)
            begin
                want = cur_row.res;
            end
            if (want.drawn)
            begin
                painted_cells.push_back(want.index);
                if (painted_cells.size() > 32) void'(painted_cells.pop_front());
            end
            expected_cells.push_back(want);
            items_sent++;
        end
    end

    task automatic send_item(input stim_row_t row, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        cur_row     = row;
        opcode      = row.op;
        point_x     = row.x;
        point_y     = row.y;
        point_z     = row.z;
        face_char   = row.fc;
        light_level = row.ll;
        cell_index  = row.ci;
        start       = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (expected_cells.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input int val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = r;
        cfg_data  = val[9:0];
        case (r)
            REG_ANGLE_A:       m_angle_a   = val[9:0];
            REG_ANGLE_B:       m_angle_b   = val[9:0];
            REG_ANGLE_C:       m_angle_c   = val[9:0];
            REG_VIEW_DISTANCE: m_view_dist = val[9:0];
            REG_SCREEN_WIDTH:  m_width     = val[7:0];
            REG_SCREEN_HEIGHT: m_height    = val[7:0];
            REG_LIGHT_ENABLE:  m_light     = val[0];
            REG_DARK_INVERT:   m_dark      = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    function automatic stim_row_t random_row();
        stim_row_t s;
        int        pick;
        s = '{OP_PLOT, 0, 0, 0, 0, 0, 0, 1'b0, '0};
        s.fc = 8'($urandom_range(0, 255));
        s.ll = 11'($urandom_range(0, 1024) - 512);
        s.ci = 14'($urandom_range(0, 16383));
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            s.op = OP_READ;
            // mostly read back cells that were painted recently
            if (pick < 15 && painted_cells.size() > 0)
            begin
                s.ci = 14'(painted_cells[$urandom_range(0, painted_cells.size() - 1)]);
            end
        end
        else if (pick < 80)
        begin
            s.x = 8'($urandom_range(0, 40) - 20);
            s.y = 8'($urandom_range(0, 40) - 20);
            s.z = 8'($urandom_range(0, 80) - 40);
        end
        else
        begin
            s.x = 8'($urandom_range(0, 255));
            s.y = 8'($urandom_range(0, 255));
            s.z = 8'($urandom_range(0, 255));
        end
        return s;
    endfunction

    stim_row_t dir_tab [15] = '{
        '{OP_READ, 0, 0, 0, 0, 0, 0, 1'b1, '{1'b0, 14'd0, 8'd32}},
        '{OP_READ, 0, 0, 0, 0, 0, 14'd16383, 1'b1, '{1'b0, 14'd16383, 8'd32}},
        '{OP_PLOT, 0, 0, 0, "A", 0, 0, 1'b1, '{1'b1, 14'd1000, "A"}},
        // same depth again loses the test
        '{OP_PLOT, 0, 0, 0, "B", 0, 0, 1'b1, '{1'b0, 14'd0, 8'd0}},
        '{OP_READ, 0, 0, 0, 0, 0, 14'd1000, 1'b1, '{1'b0, 14'd1000, "A"}},
        // behind the viewer, then exactly at the eye
        '{OP_PLOT, 0, 0, -128, 8'd7, 0, 0, 1'b1, '{1'b0, 14'd0, 8'd0}},
        '{OP_PLOT, 0, 0, -120, 8'd7, 0, 0, 1'b0, '0},
        '{OP_PLOT, 127, 127, 127, 8'd255, 11'sd512, 0, 1'b0, '0},
        '{OP_PLOT, -128, -128, 127, 8'd0, -11'sd512, 0, 1'b0, '0},
        // tiny depth gives huge projections
        '{OP_PLOT, 127, -128, -119, 8'd1, 0, 0, 1'b0, '0},
        '{OP_PLOT, -128, 127, -119, 8'd2, 0, 0, 1'b0, '0},
        '{OP_PLOT, 1, 0, -119, 8'd3, 0, 0, 1'b0, '0},
        '{OP_PLOT, 0, 0, 0, 8'd9, -11'sd512, 0, 1'b0, '0},
        '{OP_PLOT, 5, 5, 5, 8'd10, 11'sd512, 0, 1'b0, '0},
        '{OP_READ, 0, 0, 0, 0, 0, 14'd16383, 1'b1, '{1'b0, 14'd16383, 8'd32}}
    };

    initial
    begin
        view_setup_t ph [8];
        view_setup_t p;
        int          gap;
        bit          burst;
        rst_n       = 1'b0;
        start       = 1'b0;
        opcode      = OP_PLOT;
        point_x     = '0;
        point_y     = '0;
        point_z     = '0;
        face_char   = '0;
        light_level = '0;
        cell_index  = '0;
        cfg_write   = 1'b0;
        cfg_index   = REG_ANGLE_A;
        cfg_data    = '0;
        cur_row     = '{OP_PLOT, 0, 0, 0, 0, 0, 0, 1'b0, '0};
        err_count   = 0;
        items_sent  = 0;
        draws_seen  = 0;
        phases_run  = 0;
        m_angle_a = 0; m_angle_b = 0; m_angle_c = 0; m_view_dist = 10'd120;
        m_width = 8'd80; m_height = 8'd24; m_light = 0; m_dark = 0;
        for (int n = 0; n < MAX_CELLS; n++)
        begin
            depth_mem[n] = '0;
            char_mem[n]  = CHAR_SPACE;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[n])
        begin
            send_item(dir_tab[n], $urandom_range(0, 5));
        end
        wait_idle();

        ph[0] = '{0, 0, 0, 120, 80, 24, 0, 0};
        ph[1] = '{1023, 1023, 1023, 1023, 255, 255, 1, 0};
        ph[2] = '{256, 512, 768, 0, 1, 1, 1, 1};
        ph[3] = '{$urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), 60, 64, 32, 1, 0};
        // zero width: nothing can land in the frame
        ph[4] = '{$urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), 200, 0, 24, 0, 1};
        ph[5] = '{$urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), 100, 80, 24, 1, 1};
        ph[6] = '{$urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), 1, 255, 64, 0, 0};
        ph[7] = '{$urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), 150, 128, 128, 1, 0};

        foreach (ph[n])
        begin
            p = ph[n];
            write_reg(REG_ANGLE_A, p.a);
            write_reg(REG_ANGLE_B, p.b);
            write_reg(REG_ANGLE_C, p.c);
            write_reg(REG_VIEW_DISTANCE, p.vd);
            write_reg(REG_SCREEN_WIDTH, p.w);
            write_reg(REG_SCREEN_HEIGHT, p.h);
            write_reg(REG_LIGHT_ENABLE, p.le);
            write_reg(REG_DARK_INVERT, p.di);
            for (int m = 0; m < 80; m++)
            begin
                if (m % 20 == 0) burst = ($urandom_range(0, 2) == 0);
                gap = burst ? 0 : $urandom_range(0, 5);
                send_item(random_row(), gap);
            end
            // hold off until the frame has caught up
            wait_idle();
            phases_run++;
        end

        $display("ran %0d items over %0d view setups plus directed rows, %0d cells painted",
                 items_sent, phases_run, draws_seen);
        if (expected_cells.size() != 0)
        begin
            report("results never arrived", expected_cells.size(), 0);
        end
        if (err_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== rotate_project_zbuffer_plot.f =====
rtl/rpzp_pkg.sv
rtl/rotate_project_zbuffer_plot.sv
rtl/rpzp_checker.sv
bench/tb_top.sv
